@@ sv/arpm_pkg.sv @@
package arpm_pkg;

    // Input sample width and period length range
    localparam int SAMPLE_BITS       = 24;
    localparam int MAX_PERIOD_GROUPS = 4096;

    // Datapath widths
    localparam int MAG_W       = 24;                       // Q1.23 magnitude, up to 2^23
    localparam int LEVEL_W     = 24;                       // Q1.23 output levels
    localparam int SQ_W        = 2 * MAG_W - 1;            // square, up to 2^46
    localparam int FILT_W      = 48;                       // mean-square filter state
    localparam int COEF_W      = 32;
    localparam int GROUPS_W    = 13;
    localparam int HOLD_W      = 16;
    localparam int FALL_W      = 16;
    localparam int GROUP_CNT_W = $clog2(MAX_PERIOD_GROUPS + 1);
    localparam int HALF_W      = FILT_W / 2;
    localparam int PROD_W      = HALF_W + COEF_W;
    localparam int SUM_W       = FILT_W + COEF_W;
    localparam int FAST_SHIFT  = COEF_W;                   // step = d * omega / 2^32
    localparam int SLOW_SHIFT  = COEF_W - 2;               // step = d * 4*omega / 2^32
    localparam int STEP_W      = SUM_W - SLOW_SHIFT;
    localparam int ROOT_IN_W   = FILT_W + 1;               // 2 * slow filter
    localparam int ROOT_OUT_W  = (ROOT_IN_W + 1) / 2;

    localparam logic [ROOT_IN_W-1:0] ROOT_START_BIT =
        ROOT_IN_W'(1) << (2 * (ROOT_OUT_W - 1));

    // Item queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_OMEGA  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_FALL   = CFG_IDX_W'(3);

    localparam logic [COEF_W-1:0]   OMEGA_RESET  = COEF_W'(870000);
    localparam logic [GROUPS_W-1:0] PERIOD_RESET = GROUPS_W'(64);
    localparam logic [HOLD_W-1:0]   HOLD_RESET   = HOLD_W'(375);
    localparam logic [FALL_W-1:0]   FALL_RESET   = FALL_W'(65000);

    // Request codes
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef struct packed {
        logic                          req_type;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_in;

    typedef struct packed {
        logic [LEVEL_W-1:0] rms_level;
        logic [LEVEL_W-1:0] peak_level;
    } t_out;

    // Classified item as queued for the back end
    typedef struct packed {
        logic             req_type;
        logic [MAG_W-1:0] mag;
    } t_item;

    typedef struct packed {
        logic [COEF_W-1:0]   omega_coef;
        logic [GROUPS_W-1:0] period_groups;
        logic [HOLD_W-1:0]   hold_periods;
        logic [FALL_W-1:0]   fall_mult;
    } t_cfg;

endpackage

@@ sv/arpm_front.sv @@
module arpm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  arpm_pkg::t_in   i_in_data,
    input  logic            i_q_full,
    output logic            o_push,
    output arpm_pkg::t_item o_item
);

    logic                             r_valid;
    arpm_pkg::t_item                  r_item;
    logic                             accept;
    logic [arpm_pkg::SAMPLE_BITS-1:0] raw;
    logic [arpm_pkg::SAMPLE_BITS-1:0] mag_raw;
    logic [arpm_pkg::MAG_W-1:0]       mag;

    assign o_in_stall = r_valid & i_q_full;
    assign o_push     = r_valid & ~i_q_full;
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_item     = r_item;

    // Most negative code folds to 2^(N-1), which still fits unsigned
    assign raw     = i_in_data.sample;
    assign mag_raw = raw[arpm_pkg::SAMPLE_BITS-1] ?
                     (~raw + arpm_pkg::SAMPLE_BITS'(1)) : raw;

    if (arpm_pkg::SAMPLE_BITS >= arpm_pkg::MAG_W) begin : g_shr
        assign mag = mag_raw[arpm_pkg::SAMPLE_BITS-1 -: arpm_pkg::MAG_W];
    end else begin : g_shl
        assign mag = {mag_raw, {(arpm_pkg::MAG_W - arpm_pkg::SAMPLE_BITS){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept | (r_valid & i_q_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.req_type <= i_in_data.req_type;
            r_item.mag      <= mag;
        end
    end

endmodule

@@ sv/arpm_queue.sv @@
module arpm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  arpm_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    output arpm_pkg::t_item o_item,
    input  logic            i_pop
);

    arpm_pkg::t_item             r_mem [arpm_pkg::QUEUE_DEPTH];
    logic [arpm_pkg::QPTR_W-1:0] r_wr;
    logic [arpm_pkg::QPTR_W-1:0] r_rd;
    logic [arpm_pkg::QCNT_W-1:0] r_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_full  = (r_count == arpm_pkg::QCNT_W'(arpm_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    function automatic logic [arpm_pkg::QPTR_W-1:0] ptr_inc(
        input logic [arpm_pkg::QPTR_W-1:0] p
    );
        return (p == arpm_pkg::QPTR_W'(arpm_pkg::QUEUE_DEPTH - 1)) ?
               '0 : p + arpm_pkg::QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (do_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + arpm_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - arpm_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

@@ sv/arpm_sqrt.sv @@
module arpm_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [arpm_pkg::ROOT_IN_W-1:0] i_radicand,
    output logic                           o_done,
    output logic [arpm_pkg::ROOT_OUT_W-1:0] o_root
);

    localparam int W = arpm_pkg::ROOT_IN_W;

    logic         r_busy;
    logic         r_done;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_acc;
    logic [W-1:0] r_bit;
    logic [W:0]   trial;
    logic         fits;

    // One result bit per cycle, restoring form
    assign trial  = (W+1)'(r_acc) + (W+1)'(r_bit);
    assign fits   = ((W+1)'(r_rem) >= trial);
    assign o_done = r_done;
    assign o_root = r_acc[arpm_pkg::ROOT_OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_radicand;
            r_acc <= '0;
            r_bit <= arpm_pkg::ROOT_START_BIT;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - W'(trial);
                r_acc <= (r_acc >> 1) + r_bit;
            end else begin
                r_acc <= r_acc >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

endmodule

@@ sv/arpm_back.sv @@
module arpm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  arpm_pkg::t_cfg  i_cfg,
    input  logic            i_q_valid,
    input  arpm_pkg::t_item i_q_item,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output arpm_pkg::t_out  o_out_data
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIFF  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_SUM   = 7'b0001000,
        S_APPLY = 7'b0010000,
        S_PEND  = 7'b0100000,
        S_ROOT  = 7'b1000000
    } t_state;

    localparam int FW  = arpm_pkg::FILT_W;
    localparam int SW  = arpm_pkg::STEP_W;
    localparam int LW  = arpm_pkg::LEVEL_W;
    localparam int GW  = arpm_pkg::GROUP_CNT_W;
    localparam int FPW = arpm_pkg::LEVEL_W + arpm_pkg::FALL_W;

    t_state r_state;
    t_state n_state;

    // Filter and meter state
    logic [FW-1:0]                   r_fast;
    logic [FW-1:0]                   r_slow;
    logic [arpm_pkg::MAG_W-1:0]      r_period_peak;
    logic [LW-1:0]                   r_held;
    logic [arpm_pkg::HOLD_W-1:0]     r_hold_cnt;
    logic [LW-1:0]                   r_rms_max;
    logic                            r_read_pending;
    logic [1:0]                      r_phase;
    logic [GW-1:0]                   r_group_cnt;
    logic                            r_slow_pass;

    // Datapath
    logic [arpm_pkg::SQ_W-1:0]       r_sq;
    logic [FW-1:0]                   r_diff;
    logic                            r_neg;
    logic [arpm_pkg::PROD_W-1:0]     r_plo;
    logic [arpm_pkg::PROD_W-1:0]     r_phi;
    logic [SW-1:0]                   r_step;

    logic                            r_out_valid;
    arpm_pkg::t_out                  r_out;

    logic                            out_free;
    logic                            take;
    logic                            take_read;
    logic [FW-1:0]                   diff_a;
    logic [FW-1:0]                   diff_b;
    logic [arpm_pkg::SUM_W-1:0]      prod_sum;
    logic [SW-1:0]                   step_next;
    logic [SW:0]                     slow_up;
    logic [FW-1:0]                   slow_next;
    logic [FW-1:0]                   fast_next;
    logic [GW-1:0]                   limit;
    logic [GW-1:0]                   group_inc;
    logic                            period_end;
    logic [FPW-1:0]                  fall_prod;
    logic                            root_start;
    logic                            root_done;
    logic [arpm_pkg::ROOT_OUT_W-1:0] root_value;
    logic [LW-1:0]                   root_sat;

    assign out_free  = ~r_out_valid | ~i_out_stall;
    assign take      = (r_state == S_IDLE) && i_q_valid &&
                       ((i_q_item.req_type != arpm_pkg::REQ_READ) || out_free);
    assign take_read = take && (i_q_item.req_type == arpm_pkg::REQ_READ);
    assign o_pop     = take;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Fast pass filters the square, slow pass follows the fast filter
    assign diff_a = r_slow_pass ? r_fast : FW'(r_sq);
    assign diff_b = r_slow_pass ? r_slow : r_fast;

    assign prod_sum  = {r_phi, arpm_pkg::HALF_W'(0)} + arpm_pkg::SUM_W'(r_plo);
    assign step_next = r_slow_pass ?
                       prod_sum[arpm_pkg::SUM_W-1:arpm_pkg::SLOW_SHIFT] :
                       SW'(prod_sum[arpm_pkg::SUM_W-1:arpm_pkg::FAST_SHIFT]);

    assign fast_next = r_neg ? (r_fast - FW'(r_step)) : (r_fast + FW'(r_step));

    // With 4*omega above one the slow step can overshoot: clamp both ways
    assign slow_up = (SW+1)'(r_slow) + (SW+1)'(r_step);
    always_comb begin
        if (r_neg) begin
            slow_next = (r_step >= SW'(r_slow)) ? '0 : (r_slow - FW'(r_step));
        end else if (slow_up[SW:FW] != '0) begin
            slow_next = '1;
        end else begin
            slow_next = slow_up[FW-1:0];
        end
    end

    always_comb begin
        if (i_cfg.period_groups == '0) begin
            limit = GW'(1);
        end else if (32'(i_cfg.period_groups) > 32'(arpm_pkg::MAX_PERIOD_GROUPS)) begin
            limit = GW'(arpm_pkg::MAX_PERIOD_GROUPS);
        end else begin
            limit = GW'(i_cfg.period_groups);
        end
    end

    assign group_inc  = r_group_cnt + GW'(1);
    assign period_end = (group_inc >= limit);

    assign fall_prod = FPW'(r_held) * FPW'(i_cfg.fall_mult);

    assign root_start = (r_state == S_PEND);
    assign root_sat   = (root_value[arpm_pkg::ROOT_OUT_W-1:LW] != '0) ?
                        '1 : root_value[LW-1:0];

    arpm_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (root_start),
        .i_radicand ({r_slow, 1'b0}),
        .o_done     (root_done),
        .o_root     (root_value)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take && !take_read) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF:  n_state = S_MUL;
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_APPLY;
            S_APPLY: begin
                if (!r_slow_pass) begin
                    n_state = (r_phase == 2'd3) ? S_DIFF : S_IDLE;
                end else begin
                    n_state = period_end ? S_PEND : S_IDLE;
                end
            end
            S_PEND:  n_state = S_ROOT;
            S_ROOT: begin
                if (root_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_fast         <= '0;
            r_slow         <= '0;
            r_period_peak  <= '0;
            r_held         <= '0;
            r_hold_cnt     <= '0;
            r_rms_max      <= '0;
            r_read_pending <= 1'b0;
            r_phase        <= '0;
            r_group_cnt    <= '0;
            r_slow_pass    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (take_read) begin
                r_out_valid    <= 1'b1;
                r_read_pending <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (take && !take_read && (i_q_item.mag > r_period_peak)) begin
                r_period_peak <= i_q_item.mag;
            end

            if (r_state == S_APPLY) begin
                if (!r_slow_pass) begin
                    r_fast      <= fast_next;
                    r_phase     <= r_phase + 2'd1;
                    r_slow_pass <= (r_phase == 2'd3);
                end else begin
                    r_slow      <= slow_next;
                    r_slow_pass <= 1'b0;
                    r_group_cnt <= period_end ? '0 : group_inc;
                end
            end

            if (r_state == S_PEND) begin
                if (r_read_pending) begin
                    r_rms_max      <= '0;
                    r_read_pending <= 1'b0;
                end
                if (r_period_peak > r_held) begin
                    r_held     <= r_period_peak;
                    r_hold_cnt <= i_cfg.hold_periods;
                end else if (r_hold_cnt != '0) begin
                    r_hold_cnt <= r_hold_cnt - arpm_pkg::HOLD_W'(1);
                end else begin
                    r_held <= fall_prod[FPW-1:arpm_pkg::FALL_W];
                end
                r_period_peak <= '0;
            end

            if ((r_state == S_ROOT) && root_done && (root_sat > r_rms_max)) begin
                r_rms_max <= root_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_read) begin
            r_out.rms_level  <= r_rms_max;
            r_out.peak_level <= r_held;
        end
        if (take) begin
            r_sq <= arpm_pkg::SQ_W'(i_q_item.mag) * arpm_pkg::SQ_W'(i_q_item.mag);
        end
        if (r_state == S_DIFF) begin
            r_neg  <= (diff_a < diff_b);
            r_diff <= (diff_a < diff_b) ? (diff_b - diff_a) : (diff_a - diff_b);
        end
        if (r_state == S_MUL) begin
            r_plo <= arpm_pkg::PROD_W'(r_diff[arpm_pkg::HALF_W-1:0]) *
                     arpm_pkg::PROD_W'(i_cfg.omega_coef);
            r_phi <= arpm_pkg::PROD_W'(r_diff[FW-1:arpm_pkg::HALF_W]) *
                     arpm_pkg::PROD_W'(i_cfg.omega_coef);
        end
        if (r_state == S_SUM) begin
            r_step <= step_next;
        end
    end

endmodule

@@ sv/audio_rms_peak_level_meter.sv @@
// Read item: after its accepting edge it passes the front register, the queue and the output
// register before its result is valid, when the back end is idle.
// Sample item: the back-end sequencer runs square, difference, 24x32 split multiply, sum and
// update; every fourth sample adds a slow-filter pass, and a period end then adds the
// one-bit-per-cycle square root. A 4-item queue absorbs the bursts.
// Reset (synchronous, active low) loads the default configuration, zeroes all meter
// state and empties the queue and output register; no clearing pass is needed.
module audio_rms_peak_level_meter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  arpm_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output arpm_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [arpm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [arpm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    arpm_pkg::t_cfg  r_cfg;
    logic            push;
    logic            q_full;
    logic            q_valid;
    logic            pop;
    arpm_pkg::t_item front_item;
    arpm_pkg::t_item q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.omega_coef    <= arpm_pkg::OMEGA_RESET;
            r_cfg.period_groups <= arpm_pkg::PERIOD_RESET;
            r_cfg.hold_periods  <= arpm_pkg::HOLD_RESET;
            r_cfg.fall_mult     <= arpm_pkg::FALL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                arpm_pkg::CFG_OMEGA: begin
                    r_cfg.omega_coef <= i_cfg_data[arpm_pkg::COEF_W-1:0];
                end
                arpm_pkg::CFG_PERIOD: begin
                    r_cfg.period_groups <= i_cfg_data[arpm_pkg::GROUPS_W-1:0];
                end
                arpm_pkg::CFG_HOLD: begin
                    r_cfg.hold_periods <= i_cfg_data[arpm_pkg::HOLD_W-1:0];
                end
                arpm_pkg::CFG_FALL: begin
                    r_cfg.fall_mult <= i_cfg_data[arpm_pkg::FALL_W-1:0];
                end
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    arpm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_item     (front_item)
    );

    arpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    arpm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
